### design/swmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swmf_pkg;

	localparam int WINDOW_DEF = 15;
	localparam int DATA_W     = 16;
	localparam int CNT_OUT_W  = 4;
	localparam int COUNT_MAX  = 15;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic load;   // write sample, copy home value into the ring
		logic scan;   // rotate ring, count matches against home value
		logic pick;   // shift ring and counts toward cell 0
	} cell_ctrl_t;

endpackage

`default_nettype wire

### design/swmf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module swmf_cell #(
	parameter int CW = 4
) (
	input  wire                           clk,
	input  wire swmf_pkg::cell_ctrl_t     ctrl,
	input  wire                           wr,
	input  wire [swmf_pkg::DATA_W-1:0]    sample,
	input  wire [swmf_pkg::DATA_W-1:0]    nxt_r,
	input  wire [CW-1:0]                  nxt_c,
	output logic [swmf_pkg::DATA_W-1:0]   r,
	output logic [CW-1:0]                 c
);

	logic [swmf_pkg::DATA_W-1:0] h_q;
	logic [swmf_pkg::DATA_W-1:0] r_q;
	logic [CW-1:0]               c_q;
	logic [swmf_pkg::DATA_W-1:0] h_new;

	assign h_new = wr ? sample : h_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			h_q <= h_new;
			r_q <= h_new;
			c_q <= '0;
		end else if (ctrl.scan) begin
			r_q <= nxt_r;
			if (r_q == h_q) begin
				c_q <= c_q + CW'(1);
			end
		end else if (ctrl.pick) begin
			r_q <= nxt_r;
			c_q <= nxt_c;
		end
	end

	assign r = r_q;
	assign c = c_q;

endmodule

`default_nettype wire

### design/sliding_window_mode_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Signals                  | Payload
// s_axis  | in  | s_tvalid/s_tready/s_tdata| speed_sample
// m_axis  | out | m_tvalid/m_tready/m_tdata| mode_speed, mode_count
//
// Per sample: a full ring rotation in the cell chain (ST_SCAN) builds every slot's
// match count, a shift pass (ST_PICK) moves the counts out past the running
// winner, and a final step (ST_DONE) loads the output register.
// arst_n clears control state; the first sample after reset fills every slot.
// A result waiting on m_tready holds only the final step; the next sample is
// taken as soon as the previous result sits in the output register.

module sliding_window_mode_filter #(
	parameter int WINDOW = swmf_pkg::WINDOW_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [swmf_pkg::IN_TDATA_W-1:0]     s_tdata,  // [15:0] speed_sample
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [swmf_pkg::OUT_TDATA_W-1:0]   m_tdata   // [15:0] mode_speed, [19:16] mode_count
);

	localparam int CW = $clog2(WINDOW + 1);
	localparam int PW = $clog2(WINDOW);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_PICK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [PW-1:0]                  phase_q;
	logic [PW-1:0]                  wslot_q;
	logic                           primed_q;
	logic [swmf_pkg::DATA_W-1:0]    best_val_q;
	logic [CW-1:0]                  best_cnt_q;
	logic                           out_valid_q;
	logic [swmf_pkg::DATA_W-1:0]    out_speed_q;
	logic [swmf_pkg::CNT_OUT_W-1:0] out_count_q;

	swmf_pkg::cell_ctrl_t           ctrl;
	logic                           accept;
	logic                           phase_last;
	logic                           out_load;
	logic [swmf_pkg::DATA_W-1:0]    r_chain [WINDOW];
	logic [CW-1:0]                  c_chain [WINDOW];
	logic [CW+3:0]                  best_wide;
	logic [swmf_pkg::CNT_OUT_W-1:0] count_sat;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign phase_last = (phase_q == PW'(WINDOW - 1));
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign ctrl.load = accept;
	assign ctrl.scan = (state_q == ST_SCAN);
	assign ctrl.pick = (state_q == ST_PICK);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		swmf_cell #(.CW(CW)) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.wr     (!primed_q || (wslot_q == PW'(i))),
			.sample (s_tdata[swmf_pkg::DATA_W-1:0]),
			.nxt_r  (r_chain[(i + 1) % WINDOW]),
			.nxt_c  (c_chain[(i + 1) % WINDOW]),
			.r      (r_chain[i]),
			.c      (c_chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			wslot_q     <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						primed_q <= 1'b1;
						phase_q  <= '0;
						state_q  <= ST_SCAN;
						// first sample fills every slot, so the next write goes to slot 1
						if (!primed_q) begin
							wslot_q <= PW'(1);
						end else if (wslot_q == PW'(WINDOW - 1)) begin
							wslot_q <= '0;
						end else begin
							wslot_q <= wslot_q + PW'(1);
						end
					end
				end
				ST_SCAN: begin
					phase_q <= phase_last ? '0 : phase_q + PW'(1);
					if (phase_last) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					phase_q <= phase_last ? '0 : phase_q + PW'(1);
					if (phase_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cell 0 presents the slots in physical order; only a strictly greater count wins
	always_ff @(posedge clk) begin
		if (accept) begin
			best_cnt_q <= '0;
			best_val_q <= '0;
		end else if (ctrl.pick && (c_chain[0] > best_cnt_q)) begin
			best_cnt_q <= c_chain[0];
			best_val_q <= r_chain[0];
		end
	end

	assign best_wide = {4'b0000, best_cnt_q};
	assign count_sat = (best_wide > (CW + 4)'(swmf_pkg::COUNT_MAX))
		? swmf_pkg::CNT_OUT_W'(swmf_pkg::COUNT_MAX)
		: best_wide[swmf_pkg::CNT_OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_speed_q <= best_val_q;
			out_count_q <= count_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_count_q, out_speed_q};

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && primed_q)
		else $error("accepted sample did not start a scan");

	a_pick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) && phase_last |=> (state_q == ST_DONE))
		else $error("pick pass did not end after WINDOW cycles");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_count_q != '0))
		else $error("mode count of zero reported");

	a_wslot_range: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |-> (wslot_q <= PW'(WINDOW - 1)))
		else $error("write slot out of window");

endmodule

`default_nettype wire
